FILE: rtl/pisu_pkg.sv
// ----------------------------------------------------------------------------
// pisu_pkg
// Shared widths, item codes and register indexes of the pixel upscaler.
// ----------------------------------------------------------------------------
package pisu_pkg;

    localparam int COL_W   = 9;   // column fields and positions
    localparam int ROW_W   = 8;   // row fields
    localparam int SCALE_W = 4;   // scale factor and pass counts
    localparam int PIX_W   = 16;  // pixel word
    localparam int ADDR_W  = 5;   // APB byte address
    localparam int DATA_W  = 32;  // APB data
    localparam int PROD_W  = COL_W + 1 + SCALE_W;  // (left+columns)*scale

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_WINDOW = 2'd0,
        RES_PIXEL  = 2'd1,
        RES_BUSY   = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        REG_WINDOW_LEFT    = 3'd0,
        REG_WINDOW_TOP     = 3'd1,
        REG_WINDOW_COLUMNS = 3'd2,
        REG_WINDOW_ROWS    = 3'd3,
        REG_SCALE_FACTOR   = 3'd4
    } cfg_reg_t;

endpackage

FILE: rtl/pisu_in_if.sv
// ----------------------------------------------------------------------------
// pisu_in_if
// Input item channel: valid/ready handshake with kind and pixel word.
// ----------------------------------------------------------------------------
interface pisu_in_if;
    logic                          valid;
    logic                          ready;
    pisu_pkg::kind_t               kind;
    logic [pisu_pkg::PIX_W-1:0]    pixel_word;

    modport source (output valid, output kind, output pixel_word, input ready);
    modport sink   (input valid, input kind, input pixel_word, output ready);
endinterface

FILE: rtl/pisu_out_if.sv
// ----------------------------------------------------------------------------
// pisu_out_if
// Result channel: valid/ready handshake with window, pixel or busy results.
// ----------------------------------------------------------------------------
interface pisu_out_if;
    logic                          valid;
    logic                          ready;
    pisu_pkg::res_kind_t           result_kind;
    logic [pisu_pkg::PIX_W-1:0]    colour;
    logic [pisu_pkg::COL_W-1:0]    start_column;
    logic [pisu_pkg::ROW_W-1:0]    start_row;
    logic [pisu_pkg::COL_W-1:0]    end_column;
    logic [pisu_pkg::ROW_W-1:0]    end_row;
    logic                          last;

    modport source (output valid, output result_kind, output colour,
                    output start_column, output start_row, output end_column,
                    output end_row, output last, input ready);
    modport sink   (input valid, input result_kind, input colour,
                    input start_column, input start_row, input end_column,
                    input end_row, input last, output ready);
endinterface

FILE: rtl/pixel_stream_integer_upscaler_unit.sv
// ----------------------------------------------------------------------------
// pixel_stream_integer_upscaler_unit
// Nearest-neighbor integer upscaler with a one-row line buffer.
// ----------------------------------------------------------------------------
// A start transaction checks the APB-programmed window against the screen and,
// if it fits, emits one address-window result with the scaled corners; window
// width and scale are latched at that point. Pixel transactions are
// byte-swapped and written into a single-port-per-direction row store (one
// write, one registered read, SCREEN_COLUMNS entries). Once a full row is in,
// the row is replayed scale times: each tick transaction reads one stored
// pixel and yields scale copies, one per cycle from the output register while
// the result sink is ready. Start, pixel and stop transactions are taken one
// per cycle while the result sink keeps up; a tick holds the input until its
// last copy leaves. Any start, pixel or stop that arrives during a replay
// returns one busy result and is otherwise dropped. The row store needs
// no clearing after reset: replay only reads entries written for the current
// row. Config registers are only to be written while the block is idle.
// ----------------------------------------------------------------------------
module pixel_stream_integer_upscaler_unit #(
    parameter int SCREEN_COLUMNS = 320,
    parameter int SCREEN_LINES   = 240,
    parameter int MAX_SCALE      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pisu_pkg::ADDR_W-1:0]   paddr,
    input  logic [pisu_pkg::DATA_W-1:0]   pwdata,
    output logic [pisu_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    pisu_in_if.sink                       pix_in,
    pisu_out_if.source                    res_out
);
    import pisu_pkg::*;

    localparam int AW = $clog2(SCREEN_COLUMNS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   left_reg;
    logic [ROW_W-1:0]   top_reg;
    logic [COL_W-1:0]   cols_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            top_reg   <= '0;
            cols_reg  <= '0;
            rows_reg  <= '0;
            scale_reg <= SCALE_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_WINDOW_LEFT:    left_reg  <= pwdata[COL_W-1:0];
                REG_WINDOW_TOP:     top_reg   <= pwdata[ROW_W-1:0];
                REG_WINDOW_COLUMNS: cols_reg  <= pwdata[COL_W-1:0];
                REG_WINDOW_ROWS:    rows_reg  <= pwdata[ROW_W-1:0];
                REG_SCALE_FACTOR:   scale_reg <= pwdata[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_WINDOW_LEFT:    prdata = DATA_W'(left_reg);
            REG_WINDOW_TOP:     prdata = DATA_W'(top_reg);
            REG_WINDOW_COLUMNS: prdata = DATA_W'(cols_reg);
            REG_WINDOW_ROWS:    prdata = DATA_W'(rows_reg);
            REG_SCALE_FACTOR:   prdata = DATA_W'(scale_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Window check and scaled corners (small 10x4 products, one level)
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] span_c, span_r;
    logic [PROD_W-1:0] sc_full, sr_full, ec_full, er_full;
    logic              win_ok;

    always_comb
    begin
        span_c  = (PROD_W'(left_reg) + PROD_W'(cols_reg)) * PROD_W'(scale_reg);
        span_r  = (PROD_W'(top_reg) + PROD_W'(rows_reg)) * PROD_W'(scale_reg);
        sc_full = PROD_W'(left_reg) * PROD_W'(scale_reg);
        sr_full = PROD_W'(top_reg) * PROD_W'(scale_reg);
        ec_full = sc_full + PROD_W'(cols_reg) * PROD_W'(scale_reg) - PROD_W'(1);
        er_full = sr_full + PROD_W'(rows_reg) * PROD_W'(scale_reg) - PROD_W'(1);
        win_ok  = (cols_reg != '0) && (rows_reg != '0) && (scale_reg != '0) &&
                  (PROD_W'(scale_reg) <= PROD_W'(MAX_SCALE)) &&
                  (span_c <= PROD_W'(SCREEN_COLUMNS)) &&
                  (span_r <= PROD_W'(SCREEN_LINES));
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic               running_reg, running_next;
    logic               usable_reg, usable_next;
    logic [COL_W-1:0]   fill_pos_reg, fill_pos_next;
    logic [SCALE_W-1:0] passes_reg, passes_next;
    logic [COL_W-1:0]   replay_pos_reg, replay_pos_next;
    logic [COL_W-1:0]   held_cols_reg, held_cols_next;
    logic [SCALE_W-1:0] held_scale_reg, held_scale_next;

    // Output register: one result descriptor, repeated ocount times
    logic               ov_reg, ov_next;
    res_kind_t          okind_reg, okind_next;
    logic [SCALE_W-1:0] ocount_reg, ocount_next;
    logic [COL_W-1:0]   osc_reg, osc_next, oec_reg, oec_next;
    logic [ROW_W-1:0]   osr_reg, osr_next, oer_reg, oer_next;

    // Row store
    logic [PIX_W-1:0]   row_store_mem [SCREEN_COLUMNS];
    logic [PIX_W-1:0]   rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [PIX_W-1:0]   wr_data;

    logic               accept, out_fire, slot_free;
    logic [COL_W:0]     fill_inc, replay_inc;

    assign out_fire      = ov_reg && res_out.ready;
    // Slot frees when the final copy of the held result leaves.
    assign slot_free     = !ov_reg || (res_out.ready && (ocount_reg == SCALE_W'(1)));
    assign pix_in.ready  = slot_free;
    assign accept        = pix_in.valid && slot_free;

    assign fill_inc   = {1'b0, fill_pos_reg} + (COL_W+1)'(1);
    assign replay_inc = {1'b0, replay_pos_reg} + (COL_W+1)'(1);
    assign wr_addr    = AW'(fill_pos_reg);
    assign rd_addr    = AW'(replay_pos_reg);
    assign wr_data    = {pix_in.pixel_word[7:0], pix_in.pixel_word[15:8]};

    always_comb
    begin
        running_next    = running_reg;
        usable_next     = usable_reg;
        fill_pos_next   = fill_pos_reg;
        passes_next     = passes_reg;
        replay_pos_next = replay_pos_reg;
        held_cols_next  = held_cols_reg;
        held_scale_next = held_scale_reg;
        ov_next         = ov_reg;
        okind_next      = okind_reg;
        ocount_next     = ocount_reg;
        osc_next        = osc_reg;
        osr_next        = osr_reg;
        oec_next        = oec_reg;
        oer_next        = oer_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        // drain the output register
        if (out_fire)
        begin
            if (ocount_reg == SCALE_W'(1))
                ov_next = 1'b0;
            else
                ocount_next = ocount_reg - SCALE_W'(1);
        end

        if (accept)
        begin
            if (pix_in.kind == KIND_TICK)
            begin
                if (passes_reg != '0)
                begin
                    mem_re      = 1'b1;
                    ov_next     = 1'b1;
                    okind_next  = RES_PIXEL;
                    ocount_next = held_scale_reg;
                    osc_next    = '0;
                    osr_next    = '0;
                    oec_next    = '0;
                    oer_next    = '0;
                    if (replay_inc >= {1'b0, held_cols_reg})
                    begin
                        replay_pos_next = '0;
                        passes_next     = passes_reg - SCALE_W'(1);
                    end
                    else
                        replay_pos_next = replay_inc[COL_W-1:0];
                end
            end
            else if (passes_reg != '0)
            begin
                // busy: start, pixel or stop during replay
                ov_next     = 1'b1;
                okind_next  = RES_BUSY;
                ocount_next = SCALE_W'(1);
                osc_next    = '0;
                osr_next    = '0;
                oec_next    = '0;
                oer_next    = '0;
            end
            else
            begin
                case (pix_in.kind)
                    KIND_START:
                    begin
                        running_next    = 1'b1;
                        usable_next     = win_ok;
                        fill_pos_next   = '0;
                        replay_pos_next = '0;
                        held_cols_next  = win_ok ? cols_reg : '0;
                        held_scale_next = win_ok ? scale_reg : '0;
                        if (win_ok)
                        begin
                            ov_next     = 1'b1;
                            okind_next  = RES_WINDOW;
                            ocount_next = SCALE_W'(1);
                            osc_next    = sc_full[COL_W-1:0];
                            osr_next    = sr_full[ROW_W-1:0];
                            oec_next    = ec_full[COL_W-1:0];
                            oer_next    = er_full[ROW_W-1:0];
                        end
                    end
                    KIND_STOP:
                    begin
                        running_next    = 1'b0;
                        usable_next     = 1'b0;
                        fill_pos_next   = '0;
                        replay_pos_next = '0;
                        held_cols_next  = '0;
                        held_scale_next = '0;
                    end
                    KIND_PIXEL:
                    begin
                        if (running_reg && usable_reg)
                        begin
                            mem_we = 1'b1;
                            if (fill_inc >= {1'b0, held_cols_reg})
                            begin
                                fill_pos_next   = '0;
                                replay_pos_next = '0;
                                passes_next     = held_scale_reg;
                            end
                            else
                                fill_pos_next = fill_inc[COL_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            usable_reg     <= 1'b0;
            fill_pos_reg   <= '0;
            passes_reg     <= '0;
            replay_pos_reg <= '0;
            held_cols_reg  <= '0;
            held_scale_reg <= '0;
            ov_reg         <= 1'b0;
            okind_reg      <= RES_WINDOW;
            ocount_reg     <= '0;
        end
        else
        begin
            running_reg    <= running_next;
            usable_reg     <= usable_next;
            fill_pos_reg   <= fill_pos_next;
            passes_reg     <= passes_next;
            replay_pos_reg <= replay_pos_next;
            held_cols_reg  <= held_cols_next;
            held_scale_reg <= held_scale_next;
            ov_reg         <= ov_next;
            okind_reg      <= okind_next;
            ocount_reg     <= ocount_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        osc_reg <= osc_next;
        osr_reg <= osr_next;
        oec_reg <= oec_next;
        oer_reg <= oer_next;
    end

    // Row store: one write and one registered read per cycle. A pixel and a
    // tick never share a cycle, and a row is complete before its first tick,
    // so no forwarding is required.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_store_mem[wr_addr] <= wr_data;
        if (mem_re)
            rdata_reg <= row_store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign res_out.valid        = ov_reg;
    assign res_out.result_kind  = okind_reg;
    assign res_out.colour       = (okind_reg == RES_PIXEL) ? rdata_reg : '0;
    assign res_out.start_column = osc_reg;
    assign res_out.start_row    = osr_reg;
    assign res_out.end_column   = oec_reg;
    assign res_out.end_row      = oer_reg;
    assign res_out.last         = (ocount_reg == SCALE_W'(1));

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_passes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        passes_reg <= held_scale_reg)
        else $error("replay pass count above latched scale");

    a_no_fill_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (passes_reg != '0) |-> (fill_pos_reg == '0))
        else $error("row fill position moved during replay");

    a_usable_latched: assert property (@(posedge clk) disable iff (!rst_n)
        usable_reg |-> (held_cols_reg != '0) && (held_scale_reg != '0))
        else $error("usable window without latched width or scale");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (ocount_reg != '0))
        else $error("held result with zero copies left");

endmodule

FILE: sim/pixel_stream_integer_upscaler_unit_tb.sv
// ----------------------------------------------------------------------------
// pixel_stream_integer_upscaler_unit_tb
// Self-checking bench for the nearest-neighbor integer pixel upscaler.
// ----------------------------------------------------------------------------
// Stream items (start, pixel, stop, tick) are sent through a valid/ready
// driver fed from a queue. The window registers are programmed over APB
// between streams, while the block is idle. Every accepted transaction runs
// through a line-buffer predictor that keeps its own copy of the stream state.
// The predictor queues the window, display-pixel and busy results it expects.
// A monitor compares each accepted result with the oldest expected one, field
// by field. Both handshake sides idle at random. A quiet stretch turns idling
// off, and one long sink hold-off makes the block back up into its input.
// ----------------------------------------------------------------------------
module pixel_stream_integer_upscaler_unit_tb;

    import pisu_pkg::*;

    localparam int SCREEN_COLUMNS   = 320;
    localparam int SCREEN_LINES     = 240;
    localparam int MAX_SCALE        = 8;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_ITEMS     = 300;
    localparam int IDLE_PERCENT     = 9;
    localparam int SINK_HOLD_CYCLES = 300;   // long hold-off, fills the block
    localparam int DRAIN_CYCLES     = 32;    // settle time once results are in
    localparam int DRAIN_LIMIT      = 50000; // cycles allowed for one drain
    localparam int SMALL_SPAN       = 8;     // most windows stay this small
    localparam int TIMEOUT          = 400000 * CLK_PERIOD;

    // one stream item waiting for the driver
    typedef struct {
        kind_t             kind;
        logic [PIX_W-1:0]  word;
    } stream_item_t;

    // one expected result transaction
    typedef struct {
        res_kind_t         result_kind;
        logic [PIX_W-1:0]  colour;
        logic [COL_W-1:0]  start_column;
        logic [ROW_W-1:0]  start_row;
        logic [COL_W-1:0]  end_column;
        logic [ROW_W-1:0]  end_row;
        logic              last;
    } upscale_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset, APB and the two channels
    // ------------------------------------------------------------------------
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b1;  // dropped by NBA at time 0
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pisu_in_if  pix_if ();
    pisu_out_if res_if ();

    always #(CLK_PERIOD / 2) clk = ~clk;

    pixel_stream_integer_upscaler_unit #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_LINES   (SCREEN_LINES),
        .MAX_SCALE      (MAX_SCALE)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_if),
        .res_out (res_if)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    stream_item_t       pending_items [$];
    upscale_result_t    expected_results [$];
    int                 error_count   = 0;
    bit                 idle_enable   = 1'b1;  // random gaps on both sides
    int                 hold_requests = 0;     // bumped to ask for a sink hold
    int                 holds_served;
    int                 hold_left;

    // ------------------------------------------------------------------------
    // Predictor state: shadow registers plus the stream and line buffer
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]   cfg_left    = '0;
    logic [ROW_W-1:0]   cfg_top     = '0;
    logic [COL_W-1:0]   cfg_columns = '0;
    logic [ROW_W-1:0]   cfg_rows    = '0;
    logic [SCALE_W-1:0] cfg_scale   = SCALE_W'(1);

    bit                 stream_active   = 1'b0;
    bit                 window_ok       = 1'b0;
    int unsigned        fill_count      = 0;
    int unsigned        passes_left     = 0;
    int unsigned        replay_index    = 0;
    int unsigned        latched_columns = 0;
    int unsigned        latched_scale   = 0;
    logic [PIX_W-1:0]   line_buffer [SCREEN_COLUMNS];

    function automatic void push_result(res_kind_t rk, logic [PIX_W-1:0] colour,
                                        int unsigned sc, int unsigned sr,
                                        int unsigned ec, int unsigned er, bit last);
        upscale_result_t r;
        r.result_kind  = rk;
        r.colour       = colour;
        r.start_column = COL_W'(sc);
        r.start_row    = ROW_W'(sr);
        r.end_column   = COL_W'(ec);
        r.end_row      = ROW_W'(er);
        r.last         = last;
        expected_results.push_back(r);
    endfunction

    function automatic void drop_stream();
        stream_active   = 1'b0;
        window_ok       = 1'b0;
        fill_count      = 0;
        passes_left     = 0;
        replay_index    = 0;
        latched_columns = 0;
        latched_scale   = 0;
    endfunction

    // Expected results of one accepted stream transaction.
    function automatic void upscale_predict(kind_t kind, logic [PIX_W-1:0] word);
        int unsigned      s;
        int unsigned      sc;
        int unsigned      sr;
        logic [PIX_W-1:0] colour;

        // a tick replays one stored pixel as latched_scale copies
        if (kind == KIND_TICK)
        begin
            if (passes_left == 0)
                return;
            colour = (replay_index < SCREEN_COLUMNS) ? line_buffer[replay_index] : '0;
            for (int n = 0; n < latched_scale; n++)
                push_result(RES_PIXEL, colour, 0, 0, 0, 0, n + 1 == latched_scale);
            replay_index++;
            if (replay_index >= latched_columns)
            begin
                replay_index = 0;
                passes_left--;
            end
            return;
        end

        // anything but a tick during replay is answered busy and dropped
        if (passes_left != 0)
        begin
            push_result(RES_BUSY, '0, 0, 0, 0, 0, 1'b1);
            return;
        end

        case (kind)
            KIND_START:
            begin
                s = cfg_scale;
                drop_stream();
                stream_active = 1'b1;
                if (cfg_columns == 0 || cfg_rows == 0 || s == 0 || s > MAX_SCALE)
                    return;
                if ((cfg_left + cfg_columns) * s > SCREEN_COLUMNS ||
                    (cfg_top + cfg_rows) * s > SCREEN_LINES)
                    return;
                window_ok       = 1'b1;
                latched_columns = cfg_columns;
                latched_scale   = s;
                sc = cfg_left * s;
                sr = cfg_top * s;
                push_result(RES_WINDOW, '0, sc, sr,
                            sc + cfg_columns * s - 1, sr + cfg_rows * s - 1, 1'b1);
            end
            KIND_STOP: drop_stream();
            default:
            begin
                // pixel: byte swap into the row, replay once the row is full
                if (!stream_active || !window_ok)
                    return;
                if (fill_count < SCREEN_COLUMNS)
                    line_buffer[fill_count] = {word[7:0], word[15:8]};
                fill_count++;
                if (fill_count >= latched_columns)
                begin
                    fill_count   = 0;
                    replay_index = 0;
                    passes_left  = latched_scale;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: pops pending items, predicts on each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        stream_item_t item;
        if (!rst_n)
        begin
            pix_if.valid      <= 1'b0;
            pix_if.kind       <= KIND_START;
            pix_if.pixel_word <= '0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
                upscale_predict(pix_if.kind, pix_if.pixel_word);
            // a held item stays put until taken; otherwise maybe offer the next
            if (!pix_if.valid || pix_if.ready)
            begin
                if (pending_items.size() != 0 &&
                    !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT))
                begin
                    item               = pending_items.pop_front();
                    pix_if.valid      <= 1'b1;
                    pix_if.kind       <= item.kind;
                    pix_if.pixel_word <= item.word;
                end
                else
                begin
                    pix_if.valid      <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink ready: random gaps, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            hold_left    = 0;
            holds_served = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else if (holds_served < hold_requests)
        begin
            holds_served++;
            hold_left = SINK_HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        upscale_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected (result_kind %0d)",
                       res_if.result_kind);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind",  want.result_kind,  res_if.result_kind);
                check_field("colour",       want.colour,       res_if.colour);
                check_field("start_column", want.start_column, res_if.start_column);
                check_field("start_row",    want.start_row,    res_if.start_row);
                check_field("end_column",   want.end_column,   res_if.end_column);
                check_field("end_row",      want.end_row,      res_if.end_row);
                check_field("last",         want.last,         res_if.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(kind_t kind, logic [PIX_W-1:0] word);
        stream_item_t item;
        item.kind = kind;
        item.word = word;
        pending_items.push_back(item);
    endfunction

    // APB write: setup then access; the register takes it on the access edge.
    task automatic write_register(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WINDOW_LEFT:    cfg_left    = value[COL_W-1:0];
            REG_WINDOW_TOP:     cfg_top     = value[ROW_W-1:0];
            REG_WINDOW_COLUMNS: cfg_columns = value[COL_W-1:0];
            REG_WINDOW_ROWS:    cfg_rows    = value[ROW_W-1:0];
            REG_SCALE_FACTOR:   cfg_scale   = value[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_window(input int unsigned lft, input int unsigned tp,
                              input int unsigned cols, input int unsigned rws,
                              input int unsigned s);
        write_register(REG_WINDOW_LEFT,    lft);
        write_register(REG_WINDOW_TOP,     tp);
        write_register(REG_WINDOW_COLUMNS, cols);
        write_register(REG_WINDOW_ROWS,    rws);
        write_register(REG_SCALE_FACTOR,   s);
    endtask

    // All items taken, all results in, then a settle wait of DRAIN_CYCLES for
    // dropped items that leave nothing behind. Polled on the falling edge, away
    // from the clocked processes.
    task automatic wait_idle();
        int  guard;
        bit  busy;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
            busy = pending_items.size() != 0 || pix_if.valid ||
                   expected_results.size() != 0;
        end
        while (busy && guard < DRAIN_LIMIT);
        if (busy)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One random window setting and one stream over it. Returns the number
    // of items that reach a usable window.
    task automatic random_setting(input int phase, output int sent);
        int unsigned s, cols, rws, lft, tp, rows_n, pick, ending, n;
        bit          usable;
        bit          large_window;
        int          queued_start;

        queued_start = pending_items.size();
        usable       = 1'b1;
        large_window = 1'b0;
        pick         = $urandom_range(0, 99);

        s    = $urandom_range(1, MAX_SCALE);
        cols = $urandom_range(1, SMALL_SPAN);
        rws  = $urandom_range(1, SMALL_SPAN);
        if (phase == 0)
        begin
            // backlog run: big scale, one to three full rows
            s    = MAX_SCALE;
            cols = 4;
            rws  = 3;
        end
        lft = $urandom_range(0, SCREEN_COLUMNS / s - cols);
        tp  = $urandom_range(0, SCREEN_LINES / s - rws);

        if (phase != 0 && pick < 10)
        begin
            // window that fails the screen check
            usable = 1'b0;
            case ($urandom_range(0, 5))
                0: cols = 0;
                1: rws  = 0;
                2: s    = 0;
                3: s    = $urandom_range(MAX_SCALE + 1, 15);
                4: lft  = $urandom_range(SCREEN_COLUMNS / s - cols + 1, 511);
                default: tp = $urandom_range(SCREEN_LINES / s - rws + 1, 255);
            endcase
        end
        else if (phase != 0 && pick < 15)
        begin
            // near full-screen window, only a partial row is streamed
            large_window = 1'b1;
            s    = 1;
            cols = $urandom_range(100, SCREEN_COLUMNS);
            rws  = $urandom_range(1, SCREEN_LINES);
            lft  = $urandom_range(0, SCREEN_COLUMNS - cols);
            tp   = $urandom_range(0, SCREEN_LINES - rws);
        end

        set_window(lft, tp, cols, rws, s);
        queue_item(KIND_START, PIX_W'($urandom));

        if (large_window)
        begin
            n = $urandom_range(1, 40);
            repeat (n) queue_item(KIND_PIXEL, PIX_W'($urandom));
            queue_item(KIND_STOP, PIX_W'($urandom));
        end
        else
        begin
            rows_n = usable ? $urandom_range(1, 3) : 1;
            repeat (rows_n)
            begin
                repeat (cols)
                begin
                    // rare noise can restart or kill the stream mid-row
                    if ($urandom_range(0, 99) < 4)
                        queue_item(kind_t'($urandom_range(0, 3)), PIX_W'($urandom));
                    queue_item(KIND_PIXEL, PIX_W'($urandom));
                end
                n = (usable && cols * s > 0) ? cols * s : 2;
                repeat (n)
                begin
                    // a start, pixel or stop dropped into the replay
                    if ($urandom_range(0, 99) < 8)
                        queue_item(kind_t'($urandom_range(0, 2)), PIX_W'($urandom));
                    queue_item(KIND_TICK, PIX_W'($urandom));
                end
            end
            ending = $urandom_range(0, 3);
            case (ending)
                0: queue_item(KIND_STOP, PIX_W'($urandom));
                1:
                begin
                    // partial row, thrown away by the stop
                    if (cols > 1)
                        repeat ($urandom_range(1, cols - 1))
                            queue_item(KIND_PIXEL, PIX_W'($urandom));
                    queue_item(KIND_STOP, PIX_W'($urandom));
                end
                2:
                begin
                    // restart while running
                    queue_item(KIND_START, PIX_W'($urandom));
                    queue_item(KIND_PIXEL, PIX_W'($urandom));
                    queue_item(KIND_STOP, PIX_W'($urandom));
                end
                default: ;  // leave it running; the next start drops it
            endcase
        end

        // backlog: hold the sink while the driver keeps offering items
        if (phase == 0)
            hold_requests++;

        sent = usable ? pending_items.size() - queued_start : 0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        int random_sent;
        int sent;
        int phase;

        random_sent = 0;
        phase       = 0;

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: zero-width window, nothing comes out
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_PIXEL, 16'hFFFF);
        queue_item(KIND_STOP,  16'h0000);
        wait_idle();

        // bottom-right single pixel, busy items during its replay, idle tick
        set_window(SCREEN_COLUMNS - 1, SCREEN_LINES - 1, 1, 1, 1);
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_PIXEL, 16'h00FF);
        queue_item(KIND_STOP,  16'h0000);
        queue_item(KIND_PIXEL, 16'h1234);
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_TICK,  16'h0000);
        queue_item(KIND_TICK,  16'hFFFF);
        queue_item(KIND_STOP,  16'h0000);
        wait_idle();

        // largest scale: one pixel fans out to eight copies per tick
        set_window(0, 0, 1, 1, MAX_SCALE);
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_PIXEL, 16'hFF00);
        repeat (MAX_SCALE) queue_item(KIND_TICK, 16'h0000);
        queue_item(KIND_STOP, 16'h0000);
        wait_idle();

        // full-screen window, restart while running, partial row dropped
        set_window(0, 0, SCREEN_COLUMNS, SCREEN_LINES, 1);
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_PIXEL, 16'hA55A);
        queue_item(KIND_START, 16'h0000);
        queue_item(KIND_PIXEL, 16'h5AA5);
        queue_item(KIND_STOP,  16'h0000);
        wait_idle();

        // random settings; a run of them with no idling on either side
        while (random_sent < RANDOM_ITEMS)
        begin
            idle_enable = (phase < 4 || phase > 9);
            random_setting(phase, sent);
            random_sent += sent;
            phase++;
        end
        idle_enable = 1'b1;

        wait_idle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
